### design/sliding_window_rate_limiter_defines.svh
// assertion helpers for the rate limiter
`ifndef SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SWRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SWRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/swrl_pkg.sv
package swrl_pkg;

  // ring geometry
  localparam int SLOTS      = 64;
  localparam int STAMP_BITS = 48;
  localparam int CUR_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int USE_W      = CUR_W + 1;
  localparam int ACT_W      = 7;

  // stream payload widths
  localparam int OP_W       = 2;
  localparam int IN_BITS    = OP_W + STAMP_BITS;
  localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W  = 8;

  // config port
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 64;

  localparam logic [STAMP_BITS-1:0] WINDOW_RESET = STAMP_BITS'(64'd1000000000);
  localparam logic [ACT_W-1:0]      ACTIVE_RESET = ACT_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_CHECK        = 2'd0,
    OP_CHECK_UPDATE = 2'd1,
    OP_FORCE_UPDATE = 2'd2,
    OP_RESTART      = 2'd3
  } swrl_op_e;

  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_ACTIVE = 2'd1,
    REG_OFFSET = 2'd2
  } swrl_reg_e;

  typedef struct packed {
    logic [STAMP_BITS-1:0] window_ticks;
    logic [ACT_W-1:0]      active_slots;
    logic [STAMP_BITS-1:0] initial_offset_ticks;
  } swrl_cfg_t;

endpackage

### design/swrl_apb_regs.sv
module swrl_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swrl_pkg::APB_AW-1:0]   paddr,
  input  logic [swrl_pkg::APB_DW-1:0]   pwdata,
  output logic [swrl_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output swrl_pkg::swrl_cfg_t           cfg_o
);
  import swrl_pkg::*;

  logic [STAMP_BITS-1:0] window_q;
  logic [ACT_W-1:0]      active_q;
  logic [STAMP_BITS-1:0] offset_q;
  logic                  wr_en;
  swrl_reg_e             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = swrl_reg_e'(paddr[4:3]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      active_q <= ACTIVE_RESET;
      offset_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WINDOW: window_q <= pwdata[STAMP_BITS-1:0];
        REG_ACTIVE: active_q <= pwdata[ACT_W-1:0];
        REG_OFFSET: offset_q <= pwdata[STAMP_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_WINDOW: prdata = APB_DW'(window_q);
      REG_ACTIVE: prdata = APB_DW'(active_q);
      REG_OFFSET: prdata = APB_DW'(offset_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.window_ticks         = window_q;
  assign cfg_o.active_slots         = active_q;
  assign cfg_o.initial_offset_ticks = offset_q;

endmodule

### design/sliding_window_rate_limiter.sv
// channel  | dir | handshake                 | payload
// s_axis   | in  | s_axis_tvalid_i/tready_o  | tdata[1:0] operation, [49:2] timestamp
// m_axis   | out | m_axis_tvalid_o/tready_i  | tdata[0] allowed
// apb      | in  | psel/penable/pready       | paddr 8*i: window, active slots, offset
//
// one request per cycle unless the skid stage is full; the result is registered
// the entry under the cursor is prefetched from the ring memory into a register,
// so the check, the write-back and the cursor step all close in the same cycle
// reset clears cursor, valid bits and output stages at once; no clearing pass
// output register plus skid stage: input stalls only when both are full
`include "sliding_window_rate_limiter_defines.svh"

module sliding_window_rate_limiter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // [1:0] operation, [49:2] timestamp, rest zero
  input  logic [swrl_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [0] allowed, rest zero
  output logic [swrl_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [swrl_pkg::APB_AW-1:0]      paddr,
  input  logic [swrl_pkg::APB_DW-1:0]      pwdata,
  output logic [swrl_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import swrl_pkg::*;

  swrl_cfg_t             cfg;
  swrl_op_e              op;
  logic [STAMP_BITS-1:0] stamp_in;
  logic                  in_fire;
  logic                  out_fire;

  logic [STAMP_BITS-1:0] ring_mem [SLOTS];
  logic [STAMP_BITS-1:0] rd_q;
  logic [SLOTS-1:0]      stamp_valid_q, stamp_valid_d;
  logic [CUR_W-1:0]      cursor_q, cursor_d, cursor_next;
  logic [USE_W-1:0]      slots_use, cursor_plus;

  logic                  entry_valid;
  logic [STAMP_BITS:0]   fresh_sum;
  logic [STAMP_BITS:0]   age;
  logic                  check_ok;
  logic                  ok;
  logic                  wr_en;

  logic                  out_valid_q, out_allowed_q;
  logic                  skid_valid_q, skid_allowed_q;

  swrl_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign op       = swrl_op_e'(s_axis_tdata_i[OP_W-1:0]);
  assign stamp_in = s_axis_tdata_i[IN_BITS-1:OP_W];

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;

  // ring entries in use: zero counts as one, above the ring size saturates
  always_comb begin
    if (cfg.active_slots == '0) begin
      slots_use = USE_W'(1);
    end else if (int'(cfg.active_slots) > SLOTS) begin
      slots_use = USE_W'(SLOTS);
    end else begin
      slots_use = USE_W'(cfg.active_slots);
    end
  end

  // cursor step with wrap
  assign cursor_plus = {1'b0, cursor_q} + USE_W'(1);
  assign cursor_next = (cursor_plus >= slots_use) ? '0 : cursor_plus[CUR_W-1:0];

  // window check against the prefetched entry
  assign entry_valid = stamp_valid_q[cursor_q];
  assign fresh_sum   = {1'b0, stamp_in} + {1'b0, cfg.initial_offset_ticks};
  assign age         = {1'b0, stamp_in} - {1'b0, rd_q};

  always_comb begin
    if (!entry_valid) begin
      check_ok = fresh_sum >= {1'b0, cfg.window_ticks};
    end else begin
      check_ok = !age[STAMP_BITS] && (age[STAMP_BITS-1:0] >= cfg.window_ticks);
    end
  end

  assign ok    = (op != OP_RESTART) && check_ok;
  assign wr_en = in_fire && ((op == OP_FORCE_UPDATE) || ((op == OP_CHECK_UPDATE) && ok));

  // next cursor and valid bits
  always_comb begin
    cursor_d      = cursor_q;
    stamp_valid_d = stamp_valid_q;
    if (in_fire && (op == OP_RESTART)) begin
      cursor_d      = '0;
      stamp_valid_d = '0;
    end else if (wr_en) begin
      cursor_d                = cursor_next;
      stamp_valid_d[cursor_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q      <= '0;
      stamp_valid_q <= '0;
    end else begin
      cursor_q      <= cursor_d;
      stamp_valid_q <= stamp_valid_d;
    end
  end

  // ring memory: write at the cursor, prefetch the entry under the next cursor
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[cursor_q] <= stamp_in;
    end
    if (wr_en && (cursor_d == cursor_q)) begin
      rd_q <= stamp_in;
    end else begin
      rd_q <= ring_mem[cursor_d];
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_allowed_q <= skid_allowed_q;
      end else if (in_fire) begin
        out_allowed_q <= ok;
      end
    end else if (in_fire) begin
      skid_allowed_q <= ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'(out_allowed_q);

  // checks
  `SWRL_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds data with output empty")
  `SWRL_ASSERT_NEXT(a_restart_clears, in_fire && (op == OP_RESTART), (cursor_q == '0) && (stamp_valid_q == '0), "restart left ring state")
  `SWRL_ASSERT_NEXT(a_force_marks, in_fire && (op == OP_FORCE_UPDATE), stamp_valid_q[$past(cursor_q)], "force update left entry invalid")

endmodule
